/* rtl/adpcm_fd_pkg.sv */
package adpcm_fd_pkg;

    localparam int BYTE_W    = 8;
    localparam int COEF_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int HIST_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int SIF_W     = 5;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int SUM_W     = 34;
    localparam int FRAC_BITS = 11;
    localparam int QUOT_W    = SUM_W - FRAC_BITS;
    localparam int ROUND_BIAS = 1024;
    localparam int NUM_COEF_REGS = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0_1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_2_3  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_4_5  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_6_7  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HIST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic decode;
        logic more;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/adpcm_frame_decoder.sv */
// Frame-based 4-bit ADPCM decoder. Feed the encoded stream one byte per
// transfer on the s_axis side; set tuser on the first header byte of a
// stream to load the starting history and sample count from the
// configuration registers (that byte and every later frame header give no
// result). Each data byte gives two 16-bit samples, high nibble first, or
// one when the frame or the stream ends on the high nibble. Every result
// carries the header byte of its frame, and tlast marks the final sample.
// Bytes without tuser after the stream has ended are dropped. A start,
// header or dropped byte is accepted and gives no result; a data byte
// is accepted and then each of its samples takes two multiply steps and
// one sum, clamp and write step, the write waiting while the output
// register holds an untaken result. The next sample's prediction needs
// the previous one, and the single shared 16x16 multiplier handles the
// two prediction taps in turn. A result waiting in the output register
// does not hold up the next byte; only the write of a new sample waits
// for it to be taken. Write configuration only while the decoder is idle.
module adpcm_frame_decoder #(
    parameter int FRAME_SAMPLES = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    // encoded byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] stream_start
    // decoded samples
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] pcm_sample, [23:16] frame_header
    output logic        m_axis_tlast    // last_sample
);

    adpcm_fd_pkg::t_dp_cmd w_cmd;
    adpcm_fd_pkg::t_dp_sts w_sts;

    // Sequencer: accept, two multiply steps, emit
    adpcm_fd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    // Registers, history, multiply-accumulate and output register
    adpcm_fd_dp #(
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule

/* rtl/adpcm_fd_ctrl.sv */
module adpcm_fd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  adpcm_fd_pkg::t_dp_sts i_sts,
    output adpcm_fd_pkg::t_dp_cmd o_cmd
);

    adpcm_fd_pkg::t_state r_state;
    adpcm_fd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adpcm_fd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            adpcm_fd_pkg::ST_IDLE: begin
                if (s_axis_tvalid && i_sts.decode) begin
                    n_state = adpcm_fd_pkg::ST_MUL1;
                end
            end
            adpcm_fd_pkg::ST_MUL1: n_state = adpcm_fd_pkg::ST_MUL2;
            adpcm_fd_pkg::ST_MUL2: n_state = adpcm_fd_pkg::ST_EMIT;
            adpcm_fd_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.more ? adpcm_fd_pkg::ST_MUL1 : adpcm_fd_pkg::ST_IDLE;
                end
            end
            default: n_state = adpcm_fd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        case (r_state)
            adpcm_fd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.accept  = s_axis_tvalid;
            end
            adpcm_fd_pkg::ST_MUL1: o_cmd.mul1 = 1'b1;
            adpcm_fd_pkg::ST_MUL2: o_cmd.mul2 = 1'b1;
            adpcm_fd_pkg::ST_EMIT: o_cmd.emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/adpcm_fd_dp.sv */
module adpcm_fd_dp #(
    parameter int FRAME_SAMPLES = 14
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [adpcm_fd_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [adpcm_fd_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic [adpcm_fd_pkg::BYTE_W-1:0]           s_axis_tdata,
    input  logic                                      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [adpcm_fd_pkg::SAMPLE_W+adpcm_fd_pkg::BYTE_W-1:0] m_axis_tdata,
    output logic                                      m_axis_tlast,
    input  adpcm_fd_pkg::t_dp_cmd                     i_cmd,
    output adpcm_fd_pkg::t_dp_sts                     o_sts
);

    localparam logic [adpcm_fd_pkg::SIF_W-1:0] FRAME_LEN =
        adpcm_fd_pkg::SIF_W'(FRAME_SAMPLES);

    logic [adpcm_fd_pkg::CFG_W-1:0]   r_coef [adpcm_fd_pkg::NUM_COEF_REGS];
    logic [adpcm_fd_pkg::HIST_W-1:0]  r_init_hist;
    logic [adpcm_fd_pkg::COUNT_W-1:0] r_total;

    logic signed [adpcm_fd_pkg::SAMPLE_W-1:0] r_prev;
    logic signed [adpcm_fd_pkg::SAMPLE_W-1:0] r_prev2;
    logic [adpcm_fd_pkg::BYTE_W-1:0]          r_hdr;
    logic [adpcm_fd_pkg::SIF_W-1:0]           r_sif;
    logic [adpcm_fd_pkg::COUNT_W-1:0]         r_left;
    logic [adpcm_fd_pkg::BYTE_W-1:0]          r_byte;
    logic                                     r_nib_sel;

    logic signed [adpcm_fd_pkg::PROD_W-1:0] r_prod;
    logic signed [adpcm_fd_pkg::ACC_W-1:0]  r_acc;

    logic                                    r_out_valid;
    logic signed [adpcm_fd_pkg::SAMPLE_W-1:0] r_out_pcm;
    logic [adpcm_fd_pkg::BYTE_W-1:0]         r_out_hdr;
    logic                                    r_out_last;

    logic [adpcm_fd_pkg::CFG_W-1:0]          w_coef_reg;
    logic [2*adpcm_fd_pkg::COEF_W-1:0]       w_pair;
    logic signed [adpcm_fd_pkg::COEF_W-1:0]  w_c1;
    logic signed [adpcm_fd_pkg::COEF_W-1:0]  w_c2;
    logic signed [adpcm_fd_pkg::COEF_W-1:0]  w_mul_a;
    logic signed [adpcm_fd_pkg::SAMPLE_W-1:0] w_mul_b;
    logic signed [adpcm_fd_pkg::PROD_W-1:0]  w_prod;
    logic signed [3:0]                       w_nib;
    logic signed [adpcm_fd_pkg::SUM_W-1:0]   w_res_ext;
    logic signed [adpcm_fd_pkg::SUM_W-1:0]   w_scaled;
    logic signed [adpcm_fd_pkg::SUM_W-1:0]   w_sum;
    logic signed [adpcm_fd_pkg::QUOT_W-1:0]  w_quot;
    logic signed [adpcm_fd_pkg::SAMPLE_W-1:0] w_y;

    // Coefficient pair: predictors 8 to 15 use zeros
    always_comb begin
        w_coef_reg = r_coef[r_hdr[6:5]];
        w_pair     = r_hdr[4] ? w_coef_reg[31:0] : w_coef_reg[63:32];
        w_c1       = r_hdr[7] ? '0 : $signed(w_pair[31:16]);
        w_c2       = r_hdr[7] ? '0 : $signed(w_pair[15:0]);
    end

    // One multiplier: first tap in the first multiply cycle, second tap after
    always_comb begin
        w_mul_a = i_cmd.mul2 ? w_c2 : w_c1;
        w_mul_b = i_cmd.mul2 ? r_prev2 : r_prev;
        w_prod  = w_mul_a * w_mul_b;
    end

    // Scaled residual, rounding bias, floor shift and clamp
    always_comb begin
        w_nib     = r_nib_sel ? $signed(r_byte[3:0]) : $signed(r_byte[7:4]);
        w_res_ext = adpcm_fd_pkg::SUM_W'(w_nib);
        w_scaled  = (w_res_ext <<< r_hdr[3:0]) <<< adpcm_fd_pkg::FRAC_BITS;
        w_sum     = adpcm_fd_pkg::SUM_W'(r_acc) + w_scaled
                  + adpcm_fd_pkg::SUM_W'(adpcm_fd_pkg::ROUND_BIAS);
        w_quot    = w_sum[adpcm_fd_pkg::SUM_W-1:adpcm_fd_pkg::FRAC_BITS];
        if (w_quot > adpcm_fd_pkg::QUOT_W'(32767)) begin
            w_y = 16'sh7FFF;
        end else if (w_quot < -adpcm_fd_pkg::QUOT_W'(32768)) begin
            w_y = 16'sh8000;
        end else begin
            w_y = w_quot[adpcm_fd_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        o_sts.decode   = !s_axis_tuser && (r_left != '0) && (r_sif < FRAME_LEN);
        o_sts.more     = !r_nib_sel && (r_left != adpcm_fd_pkg::COUNT_W'(1))
                       && ((r_sif + 1'b1) < FRAME_LEN);
        o_sts.out_free = !r_out_valid || m_axis_tready;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < adpcm_fd_pkg::NUM_COEF_REGS; i++) begin
                r_coef[i] <= '0;
            end
            r_init_hist <= '0;
            r_total     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                adpcm_fd_pkg::CFG_COEF_0_1,
                adpcm_fd_pkg::CFG_COEF_2_3,
                adpcm_fd_pkg::CFG_COEF_4_5,
                adpcm_fd_pkg::CFG_COEF_6_7: r_coef[i_cfg_addr[1:0]] <= i_cfg_wdata;
                adpcm_fd_pkg::CFG_INIT_HIST: r_init_hist <= i_cfg_wdata[31:0];
                adpcm_fd_pkg::CFG_TOTAL:     r_total     <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_prev2   <= '0;
            r_hdr     <= '0;
            r_sif     <= '0;
            r_left    <= '0;
            r_nib_sel <= 1'b0;
        end else if (i_cmd.accept) begin
            if (s_axis_tuser) begin
                r_prev  <= $signed(r_init_hist[31:16]);
                r_prev2 <= $signed(r_init_hist[15:0]);
                r_left  <= r_total;
                r_hdr   <= s_axis_tdata;
                r_sif   <= '0;
            end else if (r_left != '0) begin
                if (r_sif >= FRAME_LEN) begin
                    r_hdr <= s_axis_tdata;
                    r_sif <= '0;
                end else begin
                    r_nib_sel <= 1'b0;
                end
            end
        end else if (i_cmd.emit) begin
            r_prev    <= w_y;
            r_prev2   <= r_prev;
            r_sif     <= r_sif + 1'b1;
            r_left    <= r_left - 1'b1;
            r_nib_sel <= 1'b1;
        end
    end

    // Multiply-accumulate: first product registered, then summed with the second
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= s_axis_tdata;
        end
        if (i_cmd.mul1) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul2) begin
            r_acc <= adpcm_fd_pkg::ACC_W'(r_prod) + adpcm_fd_pkg::ACC_W'(w_prod);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pcm  <= w_y;
            r_out_hdr  <= r_hdr;
            r_out_last <= (r_left == adpcm_fd_pkg::COUNT_W'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_hdr, r_out_pcm};
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || m_axis_tready))
        else $error("result overwrites an untaken result");

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_left != '0))
        else $error("sample emitted with no samples left");

    a_emit_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_sif < FRAME_LEN))
        else $error("sample emitted beyond frame length");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted result not presented");
`endif

endmodule
